### rtl/wavp_pkg.sv
// ----------------------------------------------------------------------------
// wavp_pkg
// shared types, codes and helpers of the wav header parser
// ----------------------------------------------------------------------------
`default_nettype none
package wavp_pkg;

	localparam logic [31:0] ID_RIFF  = 32'h46464952;
	localparam logic [31:0] ID_FMT   = 32'h20746D66;
	localparam logic [31:0] ID_DATA  = 32'h61746164;
	localparam logic [31:0] TAG_WAVE = 32'h57415645;
	localparam logic [30:0] MAX31    = 31'h7FFFFFFF;

	// result queue depth, power of two, at least 2
	localparam int QDEPTH = 4;

	typedef enum logic [2:0] {
		PH_RIFF = 3'd0,
		PH_WAVE = 3'd1,
		PH_SUB  = 3'd2,
		PH_FMT  = 3'd3,
		PH_SKIP = 3'd4,
		PH_DATA = 3'd5,
		PH_WAIT = 3'd6
	} phase_t;

	localparam logic [1:0] K_FORMAT = 2'd0;
	localparam logic [1:0] K_SAMPLE = 2'd1;
	localparam logic [1:0] K_STATUS = 2'd2;

	localparam logic [3:0] ST_OK       = 4'd0;
	localparam logic [3:0] ST_NO_RIFF  = 4'd1;
	localparam logic [3:0] ST_NO_WAVE  = 4'd2;
	localparam logic [3:0] ST_NO_FMT   = 4'd3;
	localparam logic [3:0] ST_NOT_PCM  = 4'd4;
	localparam logic [3:0] ST_CHANNELS = 4'd5;
	localparam logic [3:0] ST_BITS     = 4'd6;
	localparam logic [3:0] ST_NO_DATA  = 4'd7;
	localparam logic [3:0] ST_TRUNC    = 4'd8;

	typedef struct packed {
		logic [1:0]  item_kind;
		logic [15:0] sample_word;
		logic [1:0]  byte_count;
		logic [1:0]  channel_count;
		logic [4:0]  sample_bits;
		logic [31:0] rate_hz;
		logic [30:0] payload_bytes;
		logic [30:0] frame_total;
		logic        reversed_order;
		logic [3:0]  status_code;
		logic        final_flag;
	} item_t;

	function automatic item_t mk_status(input logic [3:0] code);
		item_t it;
		it = '0;
		it.item_kind = K_STATUS;
		it.status_code = code;
		it.final_flag = 1'b1;
		return it;
	endfunction

	function automatic item_t mk_sample(input logic [15:0] w, input logic [1:0] cnt);
		item_t it;
		it = '0;
		it.item_kind = K_SAMPLE;
		it.sample_word = w;
		it.byte_count = cnt;
		return it;
	endfunction

	function automatic logic [31:0] swap32(input logic [31:0] v);
		return {v[7:0], v[15:8], v[23:16], v[31:24]};
	endfunction

endpackage
`default_nettype wire

### rtl/wavp_front.sv
// ----------------------------------------------------------------------------
// wavp_front
// byte parser: walks the chunks and classifies each beat into result items
// ----------------------------------------------------------------------------
`default_nettype none
module wavp_front import wavp_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        take,
	input  wire logic [7:0]  in_byte,
	input  wire logic        end_of_file,
	output item_t            item_a,
	output item_t            item_b,
	output logic [1:0]       item_n
);

	phase_t      ph_q, ph_n;
	logic [3:0]  idx_q, idx_n;
	logic [31:0] tag_q, tag_n, crem_q, crem_n, rrem_q, rrem_n, rate_q, rate_n;
	logic        rev_q, rev_n, fs_q, fs_n;
	logic [15:0] ft_q, ft_n, ch_q, ch_n, bt_q, bt_n;
	logic [8:0]  pd_q, pd_n;

	function automatic logic [31:0] dec_sat(input logic [31:0] v);
		return (v == '0) ? v : v - 32'd1;
	endfunction

	function automatic logic [31:0] with_pad(input logic [31:0] v);
		return (v == 32'hFFFFFFFF) ? v : v + {31'd0, v[0]};
	endfunction

	function automatic logic [31:0] place(input logic [31:0] f, input logic [7:0] b,
			input logic [1:0] k, input logic [1:0] last, input logic rv);
		logic [1:0] sh;
		sh = rv ? last - k : k;
		return f | ({24'd0, b} << {sh, 3'b000});
	endfunction

	always_comb begin
		item_t       it [2];
		logic [1:0]  n;
		logic [3:0]  miss;
		logic [31:0] tg, sz, t32;
		logic [30:0] pay;
		logic [1:0]  shf;
		logic [15:0] w;
		item_t       fi;
		it[0] = '0;
		it[1] = '0;
		n = 2'd0;
		miss = fs_q ? ST_NO_DATA : ST_NO_FMT;
		tg = '0;
		sz = '0;
		t32 = '0;
		pay = '0;
		shf = '0;
		w = '0;
		fi = '0;
		ph_n = ph_q; idx_n = idx_q; tag_n = tag_q; crem_n = crem_q; rrem_n = rrem_q;
		rev_n = rev_q; fs_n = fs_q; ft_n = ft_q; ch_n = ch_q; bt_n = bt_q;
		rate_n = rate_q; pd_n = pd_q;
		if (take) begin
			unique case (ph_q)
				PH_RIFF: begin
					if (idx_q < 4'd4) tag_n = {tag_q[23:0], in_byte};
					else crem_n = {crem_q[23:0], in_byte};
					idx_n = idx_q + 4'd1;
					if (idx_q == 4'd3) begin
						if (swap32(tag_n) == ID_RIFF) rev_n = 1'b0;
						else if (tag_n == ID_RIFF) rev_n = 1'b1;
						else begin
							it[n[0]] = mk_status(ST_NO_RIFF); n = n + 2'd1; ph_n = PH_WAIT;
						end
					end else if (idx_q == 4'd7) begin
						rrem_n = rev_q ? crem_n : swap32(crem_n);
						crem_n = '0;
						idx_n = '0;
						ph_n = PH_WAVE;
					end
				end
				PH_WAVE: begin
					rrem_n = dec_sat(rrem_q);
					tag_n = {tag_q[23:0], in_byte};
					idx_n = idx_q + 4'd1;
					if (idx_q >= 4'd3) begin
						idx_n = '0;
						if (tag_n != TAG_WAVE) begin
							it[n[0]] = mk_status(ST_NO_WAVE); n = n + 2'd1; ph_n = PH_WAIT;
						end else ph_n = PH_SUB;
					end
				end
				PH_SUB: begin
					if (idx_q == 4'd0 && rrem_q == '0) begin
						it[n[0]] = mk_status(miss); n = n + 2'd1; ph_n = PH_WAIT;
					end else begin
						rrem_n = dec_sat(rrem_q);
						if (idx_q < 4'd4) tag_n = {tag_q[23:0], in_byte};
						else crem_n = {crem_q[23:0], in_byte};
						idx_n = idx_q + 4'd1;
						if (idx_q >= 4'd7) begin
							tg = rev_q ? tag_n : swap32(tag_n);
							sz = rev_q ? crem_n : swap32(crem_n);
							idx_n = '0;
							if (tg == ID_FMT && !fs_q) begin
								if (sz < 32'd16) begin
									it[n[0]] = mk_status(ST_NO_FMT); n = n + 2'd1; ph_n = PH_WAIT;
								end else begin
									crem_n = sz; ft_n = '0; ch_n = '0; bt_n = '0; rate_n = '0;
									ph_n = PH_FMT;
								end
							end else if (tg == ID_DATA) begin
								if (!fs_q) begin
									it[n[0]] = mk_status(ST_NO_FMT); n = n + 2'd1; ph_n = PH_WAIT;
								end else begin
									// bytes per frame is 1, 2 or 4 once fmt passed its checks
									pay = sz[31] ? MAX31 : sz[30:0];
									shf = {1'b0, ch_q == 16'd2} + {1'b0, bt_q == 16'd16};
									fi.item_kind = K_FORMAT;
									fi.channel_count = ch_q[1:0];
									fi.sample_bits = bt_q[4:0];
									fi.rate_hz = rate_q;
									fi.payload_bytes = pay;
									fi.frame_total = pay >> shf;
									fi.reversed_order = rev_q;
									it[n[0]] = fi; n = n + 2'd1;
									crem_n = sz;
									pd_n = '0;
									if (sz == '0) begin
										it[n[0]] = mk_status(ST_OK); n = n + 2'd1; ph_n = PH_WAIT;
									end else ph_n = PH_DATA;
								end
							end else if (sz > rrem_n) begin
								it[n[0]] = mk_status(miss); n = n + 2'd1; ph_n = PH_WAIT;
							end else begin
								crem_n = with_pad(sz);
								ph_n = (crem_n != '0) ? PH_SKIP : PH_SUB;
							end
						end
					end
				end
				PH_FMT: begin
					rrem_n = dec_sat(rrem_q);
					crem_n = dec_sat(crem_q);
					if (idx_q < 4'd2) begin
						t32 = place({16'd0, ft_q}, in_byte, idx_q[1:0], 2'd1, rev_q);
						ft_n = t32[15:0];
					end else if (idx_q < 4'd4) begin
						t32 = place({16'd0, ch_q}, in_byte, idx_q[1:0] - 2'd2, 2'd1, rev_q);
						ch_n = t32[15:0];
					end else if (idx_q < 4'd8) begin
						rate_n = place(rate_q, in_byte, idx_q[1:0], 2'd3, rev_q);
					end else if (idx_q >= 4'd14) begin
						t32 = place({16'd0, bt_q}, in_byte, idx_q[1:0] - 2'd2, 2'd1, rev_q);
						bt_n = t32[15:0];
					end
					idx_n = idx_q + 4'd1;
					if (idx_q == 4'd15) begin
						idx_n = '0;
						if (ft_n != 16'd1) begin
							it[n[0]] = mk_status(ST_NOT_PCM); n = n + 2'd1; ph_n = PH_WAIT;
						end else if (ch_n != 16'd1 && ch_n != 16'd2) begin
							it[n[0]] = mk_status(ST_CHANNELS); n = n + 2'd1; ph_n = PH_WAIT;
						end else if (bt_n != 16'd8 && bt_n != 16'd16) begin
							it[n[0]] = mk_status(ST_BITS); n = n + 2'd1; ph_n = PH_WAIT;
						end else begin
							fs_n = 1'b1;
							crem_n = with_pad(crem_n);
							ph_n = (crem_n != '0) ? PH_SKIP : PH_SUB;
						end
					end
				end
				PH_SKIP: begin
					rrem_n = dec_sat(rrem_q);
					crem_n = dec_sat(crem_q);
					if (crem_n == '0) begin
						idx_n = '0;
						ph_n = PH_SUB;
					end
				end
				PH_DATA: begin
					if (bt_q == 16'd8) begin
						it[n[0]] = mk_sample({8'd0, in_byte}, 2'd1); n = n + 2'd1;
					end else if (pd_q[8]) begin
						w = rev_q ? {pd_q[7:0], in_byte} : {in_byte, pd_q[7:0]};
						it[n[0]] = mk_sample(w, 2'd2); n = n + 2'd1;
						pd_n = '0;
					end else pd_n = {1'b1, in_byte};
					crem_n = dec_sat(crem_q);
					if (crem_n == '0) begin
						if (pd_n[8]) begin
							it[n[0]] = mk_sample({8'd0, pd_n[7:0]}, 2'd1); n = n + 2'd1;
							pd_n = '0;
						end
						it[n[0]] = mk_status(ST_OK); n = n + 2'd1; ph_n = PH_WAIT;
					end
				end
				PH_WAIT: ph_n = PH_WAIT;
				default: ph_n = PH_WAIT;
			endcase
			if (end_of_file) begin
				if (ph_n != PH_WAIT) begin
					if (ph_n == PH_RIFF) it[n[0]] = mk_status(ST_NO_RIFF);
					else if (ph_n == PH_WAVE) it[n[0]] = mk_status(ST_NO_WAVE);
					else if (ph_n == PH_DATA) begin
						if (pd_n[8]) begin
							it[n[0]] = mk_sample({8'd0, pd_n[7:0]}, 2'd1); n = n + 2'd1;
						end
						it[n[0]] = mk_status(ST_TRUNC);
					end else it[n[0]] = mk_status(miss);
					n = n + 2'd1;
				end
				ph_n = PH_RIFF; idx_n = '0; tag_n = '0; crem_n = '0; rrem_n = '0;
				rev_n = 1'b0; fs_n = 1'b0; ft_n = '0; ch_n = '0; bt_n = '0;
				rate_n = '0; pd_n = '0;
			end
		end
		item_a = it[0];
		item_b = it[1];
		item_n = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_RIFF; idx_q <= '0; tag_q <= '0; crem_q <= '0; rrem_q <= '0;
			rev_q <= 1'b0; fs_q <= 1'b0; ft_q <= '0; ch_q <= '0; bt_q <= '0;
			rate_q <= '0; pd_q <= '0;
		end else begin
			ph_q <= ph_n; idx_q <= idx_n; tag_q <= tag_n; crem_q <= crem_n; rrem_q <= rrem_n;
			rev_q <= rev_n; fs_q <= fs_n; ft_q <= ft_n; ch_q <= ch_n; bt_q <= bt_n;
			rate_q <= rate_n; pd_q <= pd_n;
		end
	end

endmodule
`default_nettype wire

### rtl/wavp_queue.sv
// ----------------------------------------------------------------------------
// wavp_queue
// short result queue: up to two items in per cycle, one out
// ----------------------------------------------------------------------------
`default_nettype none
module wavp_queue import wavp_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  item_t            wr_a,
	input  item_t            wr_b,
	input  wire logic [1:0]  wr_n,
	input  wire logic        rd,
	output item_t            rd_item,
	output logic             q_empty,
	output logic             q_room2,
	output logic [$clog2(QDEPTH):0] q_count
);

	localparam int AW = $clog2(QDEPTH);

	item_t            mem [QDEPTH];
	logic [AW-1:0]    wp_q, rp_q;
	logic [AW:0]      cnt_q;
	logic             do_rd;

	assign do_rd   = rd && (cnt_q != '0);
	assign rd_item = mem[rp_q];
	assign q_empty = (cnt_q == '0);
	assign q_room2 = (cnt_q <= (AW+1)'(QDEPTH - 2));
	assign q_count = cnt_q;

	always_ff @(posedge clk) begin
		if (wr_n != 2'd0) mem[wp_q] <= wr_a;
		if (wr_n == 2'd2) mem[wp_q + AW'(1)] <= wr_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			wp_q <= wp_q + AW'(wr_n);
			if (do_rd) rp_q <= rp_q + AW'(1);
			cnt_q <= cnt_q + (AW+1)'(wr_n) - (AW+1)'(do_rd);
		end
	end

endmodule
`default_nettype wire

### rtl/wav_header_parser_unit.sv
// ----------------------------------------------------------------------------
// wav_header_parser_unit
// streaming wav header parser: one file byte per beat in, format, sample
// and status items out through a short result queue
// ----------------------------------------------------------------------------
// channel   direction  handshake      payload
// bytes     in         push / full    in_byte, end_of_file
// results   out        pop / empty    item_kind .. final_flag
//
// one byte per cycle sustained while full stays low; the parser registers its state
// and writes up to two items per byte into a four-entry result queue
// full rises while fewer than two queue slots are free, so a stalled
// consumer holds off the byte side only once the queue backs up
// reset clears the parser state and empties the queue; end_of_file
// returns the parser to its reset state for the next file
// ----------------------------------------------------------------------------
`default_nettype none
module wav_header_parser_unit import wavp_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [7:0]  in_byte,
	input  wire logic        end_of_file,
	output logic             empty,
	input  wire logic        pop,
	output logic [1:0]       item_kind,
	output logic [15:0]      sample_word,
	output logic [1:0]       byte_count,
	output logic [1:0]       channel_count,
	output logic [4:0]       sample_bits,
	output logic [31:0]      rate_hz,
	output logic [30:0]      payload_bytes,
	output logic [30:0]      frame_total,
	output logic             reversed_order,
	output logic [3:0]       status_code,
	output logic             final_flag
);

	// front side: byte beat accepted when there is room for its worst case
	logic        take;
	logic        room2;
	item_t       item_a, item_b, head;
	logic [1:0]  item_n;
	logic [$clog2(QDEPTH):0] qcnt;

	assign full = !room2;
	assign take = push && room2;

	wavp_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.in_byte     (in_byte),
		.end_of_file (end_of_file),
		.item_a      (item_a),
		.item_b      (item_b),
		.item_n      (item_n)
	);

	// back side: queue head drives the result ports directly
	wavp_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_a    (item_a),
		.wr_b    (item_b),
		.wr_n    (item_n),
		.rd      (pop),
		.rd_item (head),
		.q_empty (empty),
		.q_room2 (room2),
		.q_count (qcnt)
	);

	assign item_kind      = head.item_kind;
	assign sample_word    = head.sample_word;
	assign byte_count     = head.byte_count;
	assign channel_count  = head.channel_count;
	assign sample_bits    = head.sample_bits;
	assign rate_hz        = head.rate_hz;
	assign payload_bytes  = head.payload_bytes;
	assign frame_total    = head.frame_total;
	assign reversed_order = head.reversed_order;
	assign status_code    = head.status_code;
	assign final_flag     = head.final_flag;

	// the queue never holds more than its depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		qcnt <= ($clog2(QDEPTH)+1)'(QDEPTH))
		else $error("result queue overflow");

	// items only come out of the parser on an accepted beat
	a_items_on_take: assert property (@(posedge clk) disable iff (!arst_n)
		!take |-> item_n == 2'd0)
		else $error("parser item without byte beat");

	// the final flag only rides on a status item
	a_final_status: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && final_flag) |-> item_kind == K_STATUS)
		else $error("final flag on non-status item");

	// an empty queue always has room for a byte beat
	a_empty_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> !full)
		else $error("full while queue empty");

endmodule
`default_nettype wire

### tb/wav_header_parser_checker.sv
// ----------------------------------------------------------------------------
// wav_header_parser_checker
// watches the byte and result channels of the wav header parser, predicts
// the items of every accepted byte and compares them in order
// ----------------------------------------------------------------------------
`default_nettype none
module wav_header_parser_checker import wavp_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	input  wire logic        full,
	input  wire logic [7:0]  in_byte,
	input  wire logic        end_of_file,
	input  wire logic        empty,
	input  wire logic        pop,
	input  wire logic [1:0]  item_kind,
	input  wire logic [15:0] sample_word,
	input  wire logic [1:0]  byte_count,
	input  wire logic [1:0]  channel_count,
	input  wire logic [4:0]  sample_bits,
	input  wire logic [31:0] rate_hz,
	input  wire logic [30:0] payload_bytes,
	input  wire logic [30:0] frame_total,
	input  wire logic        reversed_order,
	input  wire logic [3:0]  status_code,
	input  wire logic        final_flag,
	output int               errors,
	output int               pending
);

	item_t want_items[$];

	phase_t      ph;
	logic [3:0]  hidx;
	logic [31:0] tag_sr, size_sr, riff_left;
	logic        rev, fmt_ok;
	logic [15:0] ftag, chans, bits;
	logic [31:0] rate;
	logic [8:0]  held;

	function automatic logic [31:0] bswap(input logic [31:0] v);
		return {v[7:0], v[15:8], v[23:16], v[31:24]};
	endfunction

	function automatic logic [31:0] ordered(input logic [31:0] v);
		return rev ? v : bswap(v);
	endfunction

	function automatic logic [31:0] dec0(input logic [31:0] v);
		return (v != 0) ? v - 1 : 0;
	endfunction

	function automatic logic [31:0] padded(input logic [31:0] v);
		return (v == 32'hFFFFFFFF) ? v : v + v[0];
	endfunction

	function automatic logic [31:0] put_byte(input logic [31:0] f, input logic [7:0] b,
			input int k, input int len);
		int sh;
		sh = rev ? (len - 1 - k) : k;
		return f | (32'(b) << (8 * (sh & 3)));
	endfunction

	task automatic clear_parser();
		ph = PH_RIFF; hidx = 0; tag_sr = 0; size_sr = 0; riff_left = 0;
		rev = 0; fmt_ok = 0; ftag = 0; chans = 0; bits = 0; rate = 0; held = 0;
	endtask

	task automatic want_item(input item_t it);
		want_items.insert(want_items.size(), it);
	endtask

	task automatic add_status(input logic [3:0] code);
		item_t it;
		it = '0;
		it.item_kind = K_STATUS;
		it.status_code = code;
		it.final_flag = 1'b1;
		want_item(it);
		ph = PH_WAIT;
	endtask

	task automatic add_sample(input logic [15:0] w, input logic [1:0] cnt);
		item_t it;
		it = '0;
		it.item_kind = K_SAMPLE;
		it.sample_word = w;
		it.byte_count = cnt;
		want_item(it);
	endtask

	// one parser step per accepted byte
	task automatic parse_byte(input logic [7:0] b, input logic eof);
		logic [3:0]  i, miss;
		logic [31:0] t, sz, pay, bpf;
		item_t       fi;
		i = hidx;
		miss = fmt_ok ? ST_NO_DATA : ST_NO_FMT;
		case (ph)
			PH_RIFF: begin
				if (i < 4) tag_sr = {tag_sr[23:0], b};
				else size_sr = {size_sr[23:0], b};
				hidx = i + 1;
				if (i == 3) begin
					if (bswap(tag_sr) == ID_RIFF) rev = 0;
					else if (tag_sr == ID_RIFF) rev = 1;
					else add_status(ST_NO_RIFF);
				end else if (i == 7) begin
					riff_left = ordered(size_sr);
					size_sr = 0;
					hidx = 0;
					ph = PH_WAVE;
				end
			end
			PH_WAVE: begin
				riff_left = dec0(riff_left);
				tag_sr = {tag_sr[23:0], b};
				hidx = i + 1;
				if (i >= 3) begin
					hidx = 0;
					if (tag_sr != TAG_WAVE) add_status(ST_NO_WAVE);
					else ph = PH_SUB;
				end
			end
			PH_SUB: begin
				if (i == 0 && riff_left == 0) begin
					add_status(miss);
				end else begin
					riff_left = dec0(riff_left);
					if (i < 4) tag_sr = {tag_sr[23:0], b};
					else size_sr = {size_sr[23:0], b};
					hidx = i + 1;
					if (i >= 7) begin
						t = ordered(tag_sr);
						sz = ordered(size_sr);
						hidx = 0;
						if (t == ID_FMT && !fmt_ok) begin
							if (sz < 16) add_status(ST_NO_FMT);
							else begin
								size_sr = sz;
								ftag = 0; chans = 0; bits = 0; rate = 0;
								ph = PH_FMT;
							end
						end else if (t == ID_DATA) begin
							if (!fmt_ok) add_status(ST_NO_FMT);
							else begin
								pay = (sz > 32'(MAX31)) ? 32'(MAX31) : sz;
								bpf = (32'(chans) * 32'(bits)) / 8;
								fi = '0;
								fi.item_kind = K_FORMAT;
								fi.channel_count = chans[1:0];
								fi.sample_bits = bits[4:0];
								fi.rate_hz = rate;
								fi.payload_bytes = pay[30:0];
								fi.frame_total = (bpf != 0) ? 31'(pay / bpf) : 31'd0;
								fi.reversed_order = rev;
								want_item(fi);
								size_sr = sz;
								held = 0;
								if (sz == 0) add_status(ST_OK);
								else ph = PH_DATA;
							end
						end else if (sz > riff_left) begin
							add_status(miss);
						end else begin
							size_sr = padded(sz);
							ph = (size_sr != 0) ? PH_SKIP : PH_SUB;
						end
					end
				end
			end
			PH_FMT: begin
				riff_left = dec0(riff_left);
				size_sr = dec0(size_sr);
				if (i < 2) ftag = 16'(put_byte(32'(ftag), b, i, 2));
				else if (i < 4) chans = 16'(put_byte(32'(chans), b, i - 2, 2));
				else if (i < 8) rate = put_byte(rate, b, i - 4, 4);
				else if (i >= 14) bits = 16'(put_byte(32'(bits), b, i - 14, 2));
				hidx = i + 1;
				if (i == 15) begin
					hidx = 0;
					if (ftag != 1) add_status(ST_NOT_PCM);
					else if (chans != 1 && chans != 2) add_status(ST_CHANNELS);
					else if (bits != 8 && bits != 16) add_status(ST_BITS);
					else begin
						fmt_ok = 1;
						size_sr = padded(size_sr);
						ph = (size_sr != 0) ? PH_SKIP : PH_SUB;
					end
				end
			end
			PH_SKIP: begin
				riff_left = dec0(riff_left);
				size_sr = dec0(size_sr);
				if (size_sr == 0) begin
					hidx = 0;
					ph = PH_SUB;
				end
			end
			PH_DATA: begin
				if (bits == 8) add_sample({8'd0, b}, 2'd1);
				else if (held[8]) begin
					add_sample(rev ? {held[7:0], b} : {b, held[7:0]}, 2'd2);
					held = 0;
				end else held = {1'b1, b};
				size_sr = dec0(size_sr);
				if (size_sr == 0) begin
					if (held[8]) begin
						add_sample({8'd0, held[7:0]}, 2'd1);
						held = 0;
					end
					add_status(ST_OK);
				end
			end
			default: ph = PH_WAIT;
		endcase
		if (eof) begin
			if (ph != PH_WAIT) begin
				if (ph == PH_RIFF) add_status(ST_NO_RIFF);
				else if (ph == PH_WAVE) add_status(ST_NO_WAVE);
				else if (ph == PH_DATA) begin
					if (held[8]) add_sample({8'd0, held[7:0]}, 2'd1);
					add_status(ST_TRUNC);
				end else add_status(miss);
			end
			clear_parser();
		end
	endtask

	item_t got;
	assign got = {item_kind, sample_word, byte_count, channel_count, sample_bits, rate_hz,
		payload_bytes, frame_total, reversed_order, status_code, final_flag};

	initial begin
		errors = 0;
		pending = 0;
		clear_parser();
	end

	// results are checked before the byte of the same edge is predicted;
	// a byte's items only reach the queue after that edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty) begin
				if (want_items.size() == 0) begin
					errors <= errors + 1;
					$display("%0t: unexpected item, actual %p", $time, got);
				end else begin
					if (got !== want_items[0]) begin
						errors <= errors + 1;
						$display("%0t: item mismatch, expected %p actual %p",
							$time, want_items[0], got);
					end
					void'(want_items.pop_front());
				end
			end
			if (push && !full) parse_byte(in_byte, end_of_file);
			pending <= want_items.size();
		end
	end

endmodule
`default_nettype wire

### tb/wav_header_parser_unit_tb.sv
// ----------------------------------------------------------------------------
// wav_header_parser_unit_tb
// drives whole and broken wav files byte by byte into the parser, with
// random gaps on the byte side and random stalls on the result side;
// the checker predicts every item and counts mismatches
// ----------------------------------------------------------------------------
`default_nettype none
module wav_header_parser_unit_tb import wavp_pkg::*;;

	logic        clk, arst_n, push, pop, end_of_file;
	logic [7:0]  in_byte;
	logic        full, empty, reversed_order, final_flag;
	logic [1:0]  item_kind, byte_count, channel_count;
	logic [15:0] sample_word;
	logic [4:0]  sample_bits;
	logic [31:0] rate_hz;
	logic [30:0] payload_bytes, frame_total;
	logic [3:0]  status_code;
	int          errors, pending;
	int          bytes_sent;
	bit          calm;     // no idling on either side while set
	byte unsigned file_bytes[$];

	wav_header_parser_unit uut (.*);
	wav_header_parser_checker chk (.*);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// watchdog
	initial begin
		#4000000;
		$display("Some tests failed");
		$finish;
	end

	// result side: random pop stalls, none in the calm stretch
	initial begin
		pop = 0;
		forever begin
			@(negedge clk);
			pop <= calm || ($urandom_range(99) >= 25);
		end
	end

	// ---- file builders ----
	task automatic add_byte(input logic [7:0] v);
		file_bytes.insert(file_bytes.size(), v);
	endtask

	// multi-byte field in file order, little-endian or big-endian in reversed mode
	task automatic put_field(input logic [31:0] v, input int len, input bit rv);
		for (int k = 0; k < len; k++)
			add_byte(rv ? v[8*(len-1-k) +: 8] : v[8*k +: 8]);
	endtask

	// chunk id: ascii text kept in file order, byte-reversed in reversed mode
	task automatic put_id(input logic [31:0] id_le, input bit rv);
		put_field(id_le, 4, rv);
	endtask

	task automatic put_wav(input bit rv, input logic [15:0] fmtc, input logic [15:0] ch,
			input logic [15:0] bt, input logic [31:0] rate, input int fmt_len,
			input int skip_len, input bit data_first, input logic [31:0] data_decl,
			input int data_real, input logic [31:0] riff_size);
		put_id(ID_RIFF, rv);
		put_field(riff_size, 4, rv);
		add_byte("W"); add_byte("A");
		add_byte("V"); add_byte("E");
		if (data_first) begin
			put_id(ID_DATA, rv); put_field(4, 4, rv);
		end
		if (skip_len >= 0) begin
			put_id(32'h5453494C, rv); put_field(skip_len, 4, rv);
			for (int k = 0; k < skip_len + (skip_len & 1); k++)
				add_byte(8'($urandom));
		end
		put_id(ID_FMT, rv); put_field(fmt_len, 4, rv);
		put_field(32'(fmtc), 2, rv); put_field(32'(ch), 2, rv); put_field(rate, 4, rv);
		put_field($urandom, 4, rv); put_field($urandom, 2, rv); put_field(32'(bt), 2, rv);
		for (int k = 16; k < fmt_len + (fmt_len & 1); k++) add_byte(8'($urandom));
		put_id(ID_DATA, rv); put_field(data_decl, 4, rv);
		for (int k = 0; k < data_real; k++) add_byte(8'($urandom));
	endtask

	// send the queued file, last byte marked; bytes change at the falling edge
	task automatic send_file();
		int n;
		n = file_bytes.size();
		for (int k = 0; k < n; k++) begin
			@(negedge clk);
			while (!calm && $urandom_range(99) < 25) begin
				push <= 0;
				@(negedge clk);
			end
			push <= 1;
			in_byte <= file_bytes[k];
			end_of_file <= (k == n - 1);
			@(posedge clk);
			while (full) @(posedge clk);
			bytes_sent++;
		end
		@(negedge clk);
		push <= 0;
		end_of_file <= 0;
		file_bytes.delete();
	endtask

	task automatic random_good_file();
		int n;
		bit rv;
		n = $urandom_range(12);
		rv = 1'($urandom_range(1));
		put_wav(rv, 16'd1, 16'($urandom_range(1, 2)),
			($urandom_range(1) == 1) ? 16'd16 : 16'd8, $urandom,
			16 + ($urandom_range(3) == 0 ? $urandom_range(5) : 0),
			$urandom_range(3) == 0 ? int'($urandom_range(5)) : -1, 1'b0, 32'(n),
			($urandom_range(4) == 0) ? int'($urandom_range(n)) : n,
			$urandom_range(7) == 0 ? $urandom_range(60) : 32'h00010000);
		// occasional corruption or trailing junk
		if ($urandom_range(9) == 0 && file_bytes.size() > 0)
			file_bytes[$urandom_range(file_bytes.size() - 1)] = 8'($urandom);
		if ($urandom_range(5) == 0)
			for (int k = $urandom_range(1, 3); k > 0; k--) add_byte(8'($urandom));
	endtask

	initial begin
		calm = 0;
		bytes_sent = 0;
		push = 0;
		in_byte = 0;
		end_of_file = 0;
		arst_n = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// ---- directed files ----
		// plain 8-bit mono, extreme rate and byte values
		put_wav(0, 1, 1, 8, 32'hFFFFFFFF, 16, -1, 0, 2, 2, 100);
		file_bytes[file_bytes.size()-2] = 8'hFF; file_bytes[file_bytes.size()-1] = 8'h00;
		send_file();
		// reversed 16-bit stereo with odd trailing byte, padded fmt tail
		put_wav(1, 1, 2, 16, 0, 17, -1, 0, 5, 5, 100); send_file();
		// empty data chunk, huge declared size truncated by end of file
		put_wav(0, 1, 2, 16, 44100, 16, 3, 0, 0, 0, 100); send_file();
		put_wav(0, 1, 1, 16, 8000, 16, -1, 0, 32'hFFFFFFFF, 3, 100); send_file();
		// format rejects and data before fmt
		put_wav(0, 3, 1, 8, 1, 16, -1, 0, 1, 1, 100); send_file();
		put_wav(1, 1, 3, 8, 1, 16, -1, 0, 1, 1, 100); send_file();
		put_wav(0, 1, 1, 24, 1, 16, -1, 0, 1, 1, 100); send_file();
		put_wav(0, 1, 1, 8, 1, 16, -1, 1, 1, 1, 100); send_file();
		// short fmt, riff range too small, skipped chunk over range
		put_wav(0, 1, 1, 8, 1, 12, -1, 0, 1, 1, 100); send_file();
		put_wav(0, 1, 1, 8, 1, 16, -1, 0, 1, 1, 4); send_file();
		put_wav(0, 1, 1, 8, 1, 16, 40, 0, 1, 1, 20); send_file();
		// bad riff id, bad wave tag, end of file in header
		file_bytes = '{8'h00, 8'h11, 8'h22, 8'h33, 8'h44}; send_file();
		file_bytes = '{"R", "I", "F", "F", 8'h08, 8'h00, 8'h00, 8'h00, "W", "X"};
		send_file();
		file_bytes = '{"R", "I"}; send_file();
		file_bytes = '{8'h00}; send_file();

		// ---- random files, with one calm stretch ----
		while (bytes_sent < 1400) begin
			calm = (bytes_sent > 600 && bytes_sent < 800);
			if ($urandom_range(9) == 0) begin
				for (int k = $urandom_range(1, 12); k > 0; k--) add_byte(8'($urandom));
			end else random_good_file();
			send_file();
		end

		wait (pending == 0);
		repeat (20) @(posedge clk);
		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
`default_nettype wire
